### rtl/core/bsac_pkg.sv
// ----------------------------------------------------------------------------
// Bounded-step array counter package
// Shared sizes, the modulus and the controller/datapath command and status
// types.
// ----------------------------------------------------------------------------
package bsac_pkg;

  // number of value cells held in the count row
  localparam int MAX_VALUES = 256;

  localparam int CELL_W  = 9;   // cell_value and max_value width
  localparam int COUNT_W = 30;  // one count, always below the modulus
  localparam int SUM_W   = 32;  // holds the sum of three counts
  localparam int LIM_W   = $clog2(MAX_VALUES + 1);

  localparam logic [SUM_W-1:0] PRIME_MOD  = SUM_W'(1000000007);
  localparam logic [SUM_W-1:0] PRIME_MOD2 = SUM_W'(2000000014);

  localparam logic [CELL_W-1:0] MAX_VALUE_RST = CELL_W'(256);

  // controller to datapath
  typedef struct packed {
    logic seed;       // first position: load ones where allowed
    logic step;       // later position: neighbor sum update
    logic sum_clear;  // last position: clear total and sweep counter
    logic shift;      // move counts down by one and add cell 0 to the total
    logic load_out;   // capture the total in the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_done;   // every allowed count has been added
  } sts_t;

endpackage

### rtl/core/bsac_dp.sv
// ----------------------------------------------------------------------------
// Bounded-step array counter datapath
// Limit register, the row of per-value count cells with their modulo-p
// neighbor adders, and the total accumulator fed by shifting the row.
// ----------------------------------------------------------------------------
module bsac_dp import bsac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CELL_W-1:0]  cfg_wdata_i,
  input  logic [CELL_W-1:0]  cell_value_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [COUNT_W-1:0] way_count_o
);

  logic [CELL_W-1:0]  max_value_q;
  logic [LIM_W-1:0]   limit;
  logic [COUNT_W-1:0] ways_q [MAX_VALUES];
  logic [COUNT_W-1:0] ways_d [MAX_VALUES];
  logic [COUNT_W-1:0] acc_q, acc_d;
  logic [LIM_W-1:0]   cnt_q, cnt_d;
  logic [SUM_W-1:0]   acc_sum;
  logic [COUNT_W-1:0] way_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RST;
    end else if (cfg_we_i) begin
      max_value_q <= cfg_wdata_i;
    end
  end

  // effective limit: min(max_value, MAX_VALUES)
  always_comb begin
    if (int'(max_value_q) > MAX_VALUES) begin
      limit = LIM_W'(MAX_VALUES);
    end else begin
      limit = LIM_W'(max_value_q);
    end
  end

  for (genvar v = 0; v < MAX_VALUES; v++) begin : g_cell
    logic               in_range;
    logic               hit;
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] right;
    logic [COUNT_W-1:0] upper;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] reduced;

    assign in_range = LIM_W'(v) < limit;
    assign hit      = in_range &&
                      (cell_value_i == '0 || int'(cell_value_i) == v + 1);

    if (v == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = ways_q[v-1];
    end

    if (v + 1 < MAX_VALUES) begin : g_right
      // neighbor above the limit counts as zero
      assign right = (LIM_W'(v + 1) < limit) ? ways_q[v+1] : '0;
      assign upper = ways_q[v+1];
    end else begin : g_top
      assign right = '0;
      assign upper = '0;
    end

    assign sum = SUM_W'(ways_q[v]) + SUM_W'(left) + SUM_W'(right);

    always_comb begin
      priority if (sum >= PRIME_MOD2) begin
        reduced = COUNT_W'(sum - PRIME_MOD2);
      end else if (sum >= PRIME_MOD) begin
        reduced = COUNT_W'(sum - PRIME_MOD);
      end else begin
        reduced = COUNT_W'(sum);
      end
    end

    always_comb begin
      priority if (cmd_i.seed) begin
        ways_d[v] = hit ? COUNT_W'(1) : '0;
      end else if (cmd_i.step) begin
        ways_d[v] = hit ? reduced : '0;
      end else if (cmd_i.shift) begin
        ways_d[v] = upper;
      end else begin
        ways_d[v] = ways_q[v];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ways_q <= ways_d;
  end

  // total: add cell 0 while the row shifts down, one value per cycle
  assign acc_sum = SUM_W'(acc_q) + SUM_W'(ways_q[0]);

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cmd_i.sum_clear) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (cmd_i.shift) begin
      acc_d = (acc_sum >= PRIME_MOD) ? COUNT_W'(acc_sum - PRIME_MOD) : COUNT_W'(acc_sum);
      cnt_d = cnt_q + LIM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      way_count_q <= acc_q;
    end
  end

  assign sts_o.sum_done = (cnt_q == limit);
  assign way_count_o    = way_count_q;

endmodule

### rtl/core/bsac_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded-step array counter controller
// Tracks the array position, runs the total sweep and owns both handshakes.
// ----------------------------------------------------------------------------
module bsac_ctrl import bsac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic end_of_array_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_SUM
  } state_e;

  state_e state_q;
  logic   first_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.seed      = accept && first_q;
    cmd_o.step      = accept && !first_q;
    cmd_o.sum_clear = accept && end_of_array_i;
    cmd_o.shift     = (state_q == S_SUM) && !sts_i.sum_done;
    cmd_o.load_out  = (state_q == S_SUM) && sts_i.sum_done && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // a new total takes the output register as the old word leaves
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            first_q <= end_of_array_i;
            if (end_of_array_i) begin
              state_q <= S_SUM;
            end
          end
        end
        S_SUM: begin
          // hold the total until the output register is free
          if (sts_i.sum_done && out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/bounded_step_array_counter_top.sv
// ----------------------------------------------------------------------------
// Bounded-step array counter
// Counts, modulo 1000000007, the arrays of values 1..min(max_value, 256) with
// neighbors at most one apart that match a streamed pattern.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+---------------------------
//   in       | input     | in_valid_i/in_stall_o   | cell_value_i, end_of_array_i
//   out      | output    | out_valid_o/out_stall_i | way_count_o
//   cfg      | input     | cfg_we_i                | cfg_wdata_i (max_value)
//
// At a position that is not last, all value cells update at once. At the last
// position the cells update, then the total of L = min(max_value, 256) counts
// is gathered by shifting the count row through one modulo adder, one value per
// cycle, and waits for the output register to be free.
// Reset sets max_value to 256 and starts a new array.
// Input words are taken while a result waits; a stalled result holds the next
// total back, and input stalls until that total is loaded.
// ----------------------------------------------------------------------------
module bounded_step_array_counter_top import bsac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CELL_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CELL_W-1:0]  cell_value_i,
  input  logic               end_of_array_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] way_count_o
);

  cmd_t cmd;
  sts_t sts;

  bsac_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .end_of_array_i (end_of_array_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  bsac_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cell_value_i (cell_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .way_count_o  (way_count_o)
  );

endmodule
